// ===== sv/xmcrc_pkg.sv =====
// Package for the XModem-CRC frame receiver: transaction types, protocol
// character codes, result kinds, phase codes and the byte-wide CRC-16 update.
// Depends on nothing; every module of the block refers to it by scoped names.
`timescale 1ns / 1ps

package xmcrc_pkg;

    // Frame geometry and offset defaults
    localparam int FRAME_BYTES       = 128;
    localparam int IDX_W             = $clog2(FRAME_BYTES);
    localparam int OFFSET_BITS_DEF   = 20;
    localparam int COMMIT_W          = 20;
    localparam int REGION_W          = 21;
    localparam logic [REGION_W-1:0] REGION_RESET = 21'h00E000;

    // Job queue between parser and emitter
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Protocol characters
    localparam logic [7:0] CH_START = 8'h43;
    localparam logic [7:0] CH_SOH   = 8'h01;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_ACK   = 8'h06;
    localparam logic [7:0] CH_NAK   = 8'h15;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] CH_TMO   = 8'hFF;
    localparam logic [7:0] CH_DBG   = 8'hEE;
    localparam logic [7:0] INV_OK   = 8'hFF;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Result kinds
    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_STAGE  = 2'd1;
    localparam logic [1:0] KIND_COMMIT = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // End codes
    localparam logic [7:0] END_DONE   = 8'd0;
    localparam logic [7:0] END_CANCEL = 8'd1;

    // Parser phases
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_WAIT_C = 3'd0;
    localparam logic [PH_W-1:0] PH_IDLE   = 3'd1;
    localparam logic [PH_W-1:0] PH_BLK    = 3'd2;
    localparam logic [PH_W-1:0] PH_INV    = 3'd3;
    localparam logic [PH_W-1:0] PH_DATA   = 3'd4;
    localparam logic [PH_W-1:0] PH_CRCH   = 3'd5;
    localparam logic [PH_W-1:0] PH_CRCL   = 3'd6;
    localparam logic [PH_W-1:0] PH_HALT   = 3'd7;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       timed_out;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          value;
        logic [IDX_W-1:0]    stage_index;
        logic [COMMIT_W-1:0] commit_offset;
        logic                last;
    } out_item_t;

    // One parsed input: one or two results
    typedef struct packed {
        logic      two;
        out_item_t r0;
        out_item_t r1;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } job_wr_t;

    function automatic out_item_t mk_item(
        input logic [1:0]          kind,
        input logic [7:0]          value,
        input logic [IDX_W-1:0]    idx,
        input logic [COMMIT_W-1:0] off,
        input logic                last
    );
        out_item_t r;
        r.kind          = kind;
        r.value         = value;
        r.stage_index   = idx;
        r.commit_offset = off;
        r.last          = last;
        return r;
    endfunction

    // Byte-wide CRC-16 update, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== sv/xmodem_crc_frame_receiver.sv =====
// XModem-CRC frame receiver, a parser front end, a job queue and a result
// emitter. Depends on xmcrc_pkg, xmcrc_front, xmcrc_queue and xmcrc_back.
`timescale 1ns / 1ps

// One input transaction carries a received byte or a receive timeout. The
// block first waits for 'C', then parses XModem frames (SOH, block, inverse
// block, 128 data bytes, big-endian CRC-16 with polynomial 0x1021 and seed 0).
// Each data byte leaves as a staged-data result with its index; a frame with a
// good CRC and the expected block that fits inside region_bytes gives a commit
// result at the running offset followed by ACK. EOT gives ACK then ended with
// code 0, CAN gives ended with code 1, and the block then ignores all input
// until reset. Input is taken at one transaction per cycle while in_stall is
// low; the parser and CRC update finish in the cycle of acceptance. Results
// leave through a single output register at one per cycle when out_stall is
// low, so an input that gives two results (EOT, timeout in the data, committed
// frame) holds the emitter for both; a four-deep job queue absorbs these and
// output stalls, and in_stall rises only when that queue is full. Each job is
// queued first, then its results pass the output register. Write region_bytes
// on the cfg channel only while the block is idle; cfg_ready is always high.

module xmodem_crc_frame_receiver #(
    parameter int OFFSET_BITS = xmcrc_pkg::OFFSET_BITS_DEF,
    parameter int QUEUE_DEPTH = xmcrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [xmcrc_pkg::REGION_W-1:0]   cfg_data,
    // received byte channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  xmcrc_pkg::in_item_t              in_data,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output xmcrc_pkg::out_item_t             out_data
);

    xmcrc_pkg::job_wr_t job_wr;
    xmcrc_pkg::job_t    head;
    logic               q_empty;
    logic               q_full;
    logic               q_pop;
    logic               in_accept;

    // Always take configuration; the register lives in the parser
    assign cfg_ready = 1'b1;

    // Hold input while the job queue has no room
    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    xmcrc_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_data   (in_data),
        .job_wr    (job_wr)
    );

    xmcrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (job_wr),
        .pop   (q_pop),
        .head  (head),
        .empty (q_empty),
        .full  (q_full)
    );

    xmcrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== sv/xmcrc_front.sv =====
// Parser front end: accepts received bytes, runs the XModem state machine and
// CRC, and pushes one job per input that gives results. Uses xmcrc_pkg.
`timescale 1ns / 1ps

module xmcrc_front #(
    parameter int OFFSET_BITS = xmcrc_pkg::OFFSET_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [xmcrc_pkg::REGION_W-1:0]      cfg_data,
    input  logic                                in_accept,
    input  xmcrc_pkg::in_item_t                 in_data,
    output xmcrc_pkg::job_wr_t                  job_wr
);

    localparam int SUM_W = ((OFFSET_BITS > xmcrc_pkg::REGION_W) ?
                            OFFSET_BITS : xmcrc_pkg::REGION_W) + 1;

    logic [xmcrc_pkg::REGION_W-1:0]  region_reg,   region_next;
    logic [xmcrc_pkg::PH_W-1:0]      phase_reg,    phase_next;
    logic [7:0]                      exp_blk_reg,  exp_blk_next;
    logic [7:0]                      prev_blk_reg, prev_blk_next;
    logic [7:0]                      rcv_blk_reg,  rcv_blk_next;
    logic [xmcrc_pkg::IDX_W-1:0]     count_reg,    count_next;
    logic [15:0]                     crc_reg,      crc_next;
    logic [7:0]                      crc_hi_reg,   crc_hi_next;
    logic [OFFSET_BITS-1:0]          offset_reg,   offset_next;

    logic [7:0]       b;
    logic [SUM_W-1:0] off_ext, off_sum, lim_cap, lim, omask;
    logic [15:0]      rx_crc;
    logic             fits;
    xmcrc_pkg::out_item_t nul;

    assign b       = in_data.timed_out ? xmcrc_pkg::CH_TMO : in_data.rx_byte;
    assign off_ext = SUM_W'(offset_reg);
    assign off_sum = off_ext + SUM_W'(xmcrc_pkg::FRAME_BYTES);
    assign lim_cap = SUM_W'(1) << OFFSET_BITS;
    assign omask   = lim_cap - SUM_W'(1);
    assign lim     = (SUM_W'(region_reg) > lim_cap) ? lim_cap : SUM_W'(region_reg);
    assign fits    = (off_sum <= lim);
    assign rx_crc  = {crc_hi_reg, b};
    assign nul     = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_SEND, 8'd0, '0, '0, 1'b0);

    always_comb
    begin
        region_next   = cfg_valid ? cfg_data : region_reg;
        phase_next    = phase_reg;
        exp_blk_next  = exp_blk_reg;
        prev_blk_next = prev_blk_reg;
        rcv_blk_next  = rcv_blk_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_hi_next   = crc_hi_reg;
        offset_next   = offset_reg;
        job_wr.push   = 1'b0;
        job_wr.job.two = 1'b0;
        job_wr.job.r0  = nul;
        job_wr.job.r1  = nul;

        if (in_accept)
        begin
            case (phase_reg)
                xmcrc_pkg::PH_WAIT_C:
                begin
                    if (b == xmcrc_pkg::CH_START)
                        phase_next = xmcrc_pkg::PH_IDLE;
                end
                xmcrc_pkg::PH_IDLE:
                begin
                    if (b == xmcrc_pkg::CH_SOH)
                    begin
                        phase_next = xmcrc_pkg::PH_BLK;
                    end
                    else if (b == xmcrc_pkg::CH_EOT)
                    begin
                        job_wr.push    = 1'b1;
                        job_wr.job.two = 1'b1;
                        job_wr.job.r0  = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_SEND,
                                             xmcrc_pkg::CH_ACK, '0, '0, 1'b0);
                        job_wr.job.r1  = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_END,
                                             xmcrc_pkg::END_DONE, '0, '0, 1'b1);
                        phase_next     = xmcrc_pkg::PH_HALT;
                    end
                    else if (b == xmcrc_pkg::CH_CAN)
                    begin
                        job_wr.push   = 1'b1;
                        job_wr.job.r0 = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_END,
                                            xmcrc_pkg::END_CANCEL, '0, '0, 1'b1);
                        phase_next    = xmcrc_pkg::PH_HALT;
                    end
                end
                xmcrc_pkg::PH_BLK:
                begin
                    rcv_blk_next = b;
                    phase_next   = xmcrc_pkg::PH_INV;
                end
                xmcrc_pkg::PH_INV:
                begin
                    if ((rcv_blk_reg ^ b) != xmcrc_pkg::INV_OK)
                    begin
                        job_wr.push   = 1'b1;
                        job_wr.job.r0 = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_SEND,
                                            xmcrc_pkg::CH_NAK, '0, '0, 1'b1);
                        phase_next    = xmcrc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        count_next = '0;
                        crc_next   = 16'h0000;
                        phase_next = xmcrc_pkg::PH_DATA;
                    end
                end
                xmcrc_pkg::PH_DATA:
                begin
                    job_wr.push = 1'b1;
                    if (in_data.timed_out)
                    begin
                        job_wr.job.two = 1'b1;
                        job_wr.job.r0  = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_SEND,
                                             xmcrc_pkg::CH_DBG, '0, '0, 1'b0);
                        job_wr.job.r1  = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_SEND,
                                             xmcrc_pkg::CH_NAK, '0, '0, 1'b1);
                        phase_next     = xmcrc_pkg::PH_IDLE;
                    end
                    else
                    begin
                        job_wr.job.r0 = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_STAGE,
                                            b, count_reg, '0, 1'b1);
                        crc_next      = xmcrc_pkg::crc16_byte(crc_reg, b);
                        count_next    = count_reg + 1'b1;
                        if (count_reg == xmcrc_pkg::IDX_W'(xmcrc_pkg::FRAME_BYTES - 1))
                            phase_next = xmcrc_pkg::PH_CRCH;
                    end
                end
                xmcrc_pkg::PH_CRCH:
                begin
                    crc_hi_next = b;
                    phase_next  = xmcrc_pkg::PH_CRCL;
                end
                xmcrc_pkg::PH_CRCL:
                begin
                    job_wr.push = 1'b1;
                    phase_next  = xmcrc_pkg::PH_IDLE;
                    if (rx_crc != crc_reg)
                    begin
                        job_wr.job.r0 = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_SEND,
                                            xmcrc_pkg::CH_NAK, '0, '0, 1'b1);
                    end
                    else if (rcv_blk_reg == prev_blk_reg)
                    begin
                        job_wr.job.r0 = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_SEND,
                                            xmcrc_pkg::CH_ACK, '0, '0, 1'b1);
                    end
                    else if (rcv_blk_reg != exp_blk_reg || !fits)
                    begin
                        job_wr.job.r0 = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_SEND,
                                            xmcrc_pkg::CH_NAK, '0, '0, 1'b1);
                    end
                    else
                    begin
                        job_wr.job.two = 1'b1;
                        job_wr.job.r0  = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_COMMIT,
                                             8'd0, '0,
                                             xmcrc_pkg::COMMIT_W'(off_ext), 1'b0);
                        job_wr.job.r1  = xmcrc_pkg::mk_item(xmcrc_pkg::KIND_SEND,
                                             xmcrc_pkg::CH_ACK, '0, '0, 1'b1);
                        prev_blk_next  = rcv_blk_reg;
                        exp_blk_next   = exp_blk_reg + 8'd1;
                        offset_next    = (off_sum > omask) ? OFFSET_BITS'(omask)
                                                           : OFFSET_BITS'(off_sum);
                    end
                end
                default:
                begin
                    phase_next = xmcrc_pkg::PH_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg   <= xmcrc_pkg::REGION_RESET;
            phase_reg    <= xmcrc_pkg::PH_WAIT_C;
            exp_blk_reg  <= 8'd1;
            prev_blk_reg <= 8'd0;
            rcv_blk_reg  <= 8'd0;
            count_reg    <= '0;
            crc_reg      <= 16'h0000;
            crc_hi_reg   <= 8'd0;
            offset_reg   <= '0;
        end
        else
        begin
            region_reg   <= region_next;
            phase_reg    <= phase_next;
            exp_blk_reg  <= exp_blk_next;
            prev_blk_reg <= prev_blk_next;
            rcv_blk_reg  <= rcv_blk_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            crc_hi_reg   <= crc_hi_next;
            offset_reg   <= offset_next;
        end
    end

`ifndef SYNTHESIS
    // Jobs only come from accepted transactions
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        job_wr.push |-> in_accept)
        else $error("job pushed without an accepted input");

    // Once halted, stay halted until reset
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == xmcrc_pkg::PH_HALT) |=> (phase_reg == xmcrc_pkg::PH_HALT))
        else $error("parser left the halted phase");
`endif

endmodule

// ===== sv/xmcrc_queue.sv =====
// Short job queue between parser and emitter, held in a small register array.
// Uses xmcrc_pkg for the job type.
`timescale 1ns / 1ps

module xmcrc_queue #(
    parameter int DEPTH = xmcrc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  xmcrc_pkg::job_wr_t wr,
    input  logic               pop,
    output xmcrc_pkg::job_t    head,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xmcrc_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign empty = (cnt_reg == CNT_W'(0));
    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign do_wr = wr.push && !full;
    assign do_rd = pop && !empty;
    assign head  = mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
            wp_next = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        if (do_rd)
            rp_next = (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr.job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.push && full))
        else $error("job pushed into a full queue");
`endif

endmodule

// ===== sv/xmcrc_back.sv =====
// Emitter back end: takes jobs from the queue and presents their one or two
// results through a registered output stage. Uses xmcrc_pkg.
`timescale 1ns / 1ps

module xmcrc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  xmcrc_pkg::job_t       head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output xmcrc_pkg::out_item_t  out_data
);

    logic                 valid_reg, valid_next;
    logic                 half_reg,  half_next;
    xmcrc_pkg::out_item_t data_reg,  data_next;
    logic                 load;

    // Output stage is free when empty or being taken this cycle
    assign load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        data_next  = data_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                data_next = half_reg ? head.r1 : head.r0;
                pop       = half_reg || !head.two;
                half_next = !half_reg && head.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef SYNTHESIS
    // The second half of a job keeps its job at the queue head
    a_half_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> !empty)
        else $error("second result pending with an empty queue");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && out_data.last))
        else $error("job dropped before its last result was loaded");
`endif

endmodule
